// ===== hdl/udf_pkg.sv =====
// ----------------------------------------------------------------------------
// udf_pkg: shared types and constants of the frame deframer
// Phase codes, status codes, the result word and the CRC-16 byte update.
// ----------------------------------------------------------------------------
package udf_pkg;

  localparam logic [7:0]  HDR_BYTE      = 8'hE6;
  localparam logic [7:0]  TAIL_BYTE     = 8'h6E;
  localparam logic [15:0] CRC_POLY      = 16'hA001;
  localparam logic [15:0] CRC_INIT      = 16'h0000;
  localparam logic [8:0]  PAYLOAD_LIMIT = 9'd256;
  localparam logic [8:0]  MAX_PAYLOAD_RST = 9'd256;

  typedef enum logic [3:0] {
    PH_HUNT1  = 4'd0,
    PH_HUNT2  = 4'd1,
    PH_SEQ_HI = 4'd2,
    PH_SEQ_LO = 4'd3,
    PH_CMD    = 4'd4,
    PH_LEN_HI = 4'd5,
    PH_LEN_LO = 4'd6,
    PH_DATA   = 4'd7,
    PH_CHK_HI = 4'd8,
    PH_CHK_LO = 4'd9,
    PH_TAIL1  = 4'd10,
    PH_TAIL2  = 4'd11
  } phase_e;

  typedef enum logic [1:0] {
    ST_VALID   = 2'd0,
    ST_CRC_ERR = 2'd1,
    ST_TAIL_ERR = 2'd2,
    ST_LEN_ERR = 2'd3
  } status_e;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_REPORT  = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data_byte;
    status_e     status;
    logic [15:0] seq_num;
    logic [7:0]  command;
    logic [15:0] payload_len;
  } result_t;

  // Reflected CRC-16 update over one byte, LSB first.
  function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== hdl/udf_parser.sv =====
// ----------------------------------------------------------------------------
// udf_parser: frame state machine and CRC accumulator
// Consumes one received byte per accepted word and produces at most one
// result word combinationally from the current state and that byte.
// ----------------------------------------------------------------------------
module udf_parser (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [8:0]       cfg_wdata_i,
  input  logic             byte_vld_i,
  input  logic [7:0]       byte_i,
  output logic             res_vld_o,
  output udf_pkg::result_t res_o
);

  udf_pkg::phase_e phase_q, phase_d;
  logic [15:0] seq_q, seq_d;
  logic [7:0]  cmd_q, cmd_d;
  logic [15:0] len_q, len_d;
  logic [8:0]  count_q, count_d;
  logic [15:0] crc_q, crc_d;
  logic [15:0] chk_q, chk_d;
  logic        tail_bad_q, tail_bad_d;
  logic [8:0]  max_q;
  logic [8:0]  limit;
  logic [15:0] crc_upd;
  logic [15:0] len_new;
  logic        tail_bad_fin;

  assign crc_upd = udf_pkg::crc16_byte(crc_q, byte_i);
  assign len_new = {len_q[15:8], byte_i};
  assign limit   = (max_q > udf_pkg::PAYLOAD_LIMIT) ? udf_pkg::PAYLOAD_LIMIT : max_q;
  assign tail_bad_fin = tail_bad_q | (byte_i != udf_pkg::TAIL_BYTE);

  always_comb begin
    phase_d    = phase_q;
    seq_d      = seq_q;
    cmd_d      = cmd_q;
    len_d      = len_q;
    count_d    = count_q;
    crc_d      = crc_q;
    chk_d      = chk_q;
    tail_bad_d = tail_bad_q;
    res_vld_o  = 1'b0;
    res_o.kind        = udf_pkg::KIND_REPORT;
    res_o.data_byte   = 8'h00;
    res_o.status      = udf_pkg::ST_VALID;
    res_o.seq_num     = seq_q;
    res_o.command     = cmd_q;
    res_o.payload_len = len_q;

    case (phase_q)
      udf_pkg::PH_HUNT1: begin
        if (byte_i == udf_pkg::HDR_BYTE) begin
          phase_d = udf_pkg::PH_HUNT2;
        end
      end
      udf_pkg::PH_HUNT2: begin
        // a broken header byte is dropped, not rescanned
        phase_d    = (byte_i == udf_pkg::HDR_BYTE) ? udf_pkg::PH_SEQ_HI : udf_pkg::PH_HUNT1;
        crc_d      = udf_pkg::CRC_INIT;
        tail_bad_d = 1'b0;
      end
      udf_pkg::PH_SEQ_HI: begin
        crc_d   = crc_upd;
        seq_d   = {byte_i, 8'h00};
        phase_d = udf_pkg::PH_SEQ_LO;
      end
      udf_pkg::PH_SEQ_LO: begin
        crc_d   = crc_upd;
        seq_d   = {seq_q[15:8], byte_i};
        phase_d = udf_pkg::PH_CMD;
      end
      udf_pkg::PH_CMD: begin
        crc_d   = crc_upd;
        cmd_d   = byte_i;
        phase_d = udf_pkg::PH_LEN_HI;
      end
      udf_pkg::PH_LEN_HI: begin
        crc_d   = crc_upd;
        len_d   = {byte_i, 8'h00};
        phase_d = udf_pkg::PH_LEN_LO;
      end
      udf_pkg::PH_LEN_LO: begin
        crc_d = crc_upd;
        len_d = len_new;
        if (len_new > {7'd0, limit}) begin
          phase_d           = udf_pkg::PH_HUNT1;
          res_vld_o         = 1'b1;
          res_o.status      = udf_pkg::ST_LEN_ERR;
          res_o.payload_len = len_new;
        end else begin
          count_d = len_new[8:0];
          phase_d = (len_new == 16'd0) ? udf_pkg::PH_CHK_HI : udf_pkg::PH_DATA;
        end
      end
      udf_pkg::PH_DATA: begin
        crc_d   = crc_upd;
        count_d = count_q - 9'd1;
        if (count_q == 9'd1) begin
          phase_d = udf_pkg::PH_CHK_HI;
        end
        res_vld_o       = 1'b1;
        res_o.kind      = udf_pkg::KIND_PAYLOAD;
        res_o.data_byte = byte_i;
      end
      udf_pkg::PH_CHK_HI: begin
        chk_d   = {byte_i, 8'h00};
        phase_d = udf_pkg::PH_CHK_LO;
      end
      udf_pkg::PH_CHK_LO: begin
        chk_d   = {chk_q[15:8], byte_i};
        phase_d = udf_pkg::PH_TAIL1;
      end
      udf_pkg::PH_TAIL1: begin
        tail_bad_d = (byte_i != udf_pkg::TAIL_BYTE);
        phase_d    = udf_pkg::PH_TAIL2;
      end
      udf_pkg::PH_TAIL2: begin
        tail_bad_d = tail_bad_fin;
        phase_d    = udf_pkg::PH_HUNT1;
        res_vld_o  = 1'b1;
        // tail error wins over checksum error
        if (tail_bad_fin) begin
          res_o.status = udf_pkg::ST_TAIL_ERR;
        end else if (~crc_q != chk_q) begin
          res_o.status = udf_pkg::ST_CRC_ERR;
        end else begin
          res_o.status = udf_pkg::ST_VALID;
        end
      end
      default: begin
        phase_d = udf_pkg::PH_HUNT1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= udf_pkg::PH_HUNT1;
      seq_q      <= 16'h0000;
      cmd_q      <= 8'h00;
      len_q      <= 16'h0000;
      count_q    <= 9'd0;
      crc_q      <= udf_pkg::CRC_INIT;
      chk_q      <= 16'h0000;
      tail_bad_q <= 1'b0;
    end else if (byte_vld_i) begin
      phase_q    <= phase_d;
      seq_q      <= seq_d;
      cmd_q      <= cmd_d;
      len_q      <= len_d;
      count_q    <= count_d;
      crc_q      <= crc_d;
      chk_q      <= chk_d;
      tail_bad_q <= tail_bad_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= udf_pkg::MAX_PAYLOAD_RST;
    end else if (cfg_we_i) begin
      max_q <= cfg_wdata_i;
    end
  end

  a_data_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == udf_pkg::PH_DATA) |-> (count_q != 9'd0))
    else $error("payload phase with no bytes due");

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q <= udf_pkg::PAYLOAD_LIMIT))
    else $error("payload count above limit");

  a_data_leaves_to_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (byte_vld_i && (phase_q == udf_pkg::PH_DATA) && (count_q == 9'd1))
      |=> (phase_q == udf_pkg::PH_CHK_HI))
    else $error("last payload byte did not move to check phase");

endmodule

// ===== hdl/udf_out_buf.sv =====
// ----------------------------------------------------------------------------
// udf_out_buf: output register with skid stage
// Holds result words for the master side; takes a new word while the
// output register still waits on the receiver.
// ----------------------------------------------------------------------------
module udf_out_buf (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  udf_pkg::result_t push_data_i,
  output logic             ready_o,
  output logic             out_vld_o,
  output udf_pkg::result_t out_data_o,
  input  logic             out_rdy_i
);

  logic             out_vld_q;
  logic             skid_vld_q;
  udf_pkg::result_t out_q;
  udf_pkg::result_t skid_q;
  logic             pop;

  assign pop        = out_vld_q & out_rdy_i;
  assign ready_o    = ~skid_vld_q;
  assign out_vld_o  = out_vld_q;
  assign out_data_o = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (!out_vld_q || pop) begin
      if (skid_vld_q) begin
        out_vld_q  <= 1'b1;
        skid_vld_q <= 1'b0;
      end else begin
        out_vld_q <= push_i;
      end
    end else if (push_i) begin
      skid_vld_q <= 1'b1;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (!out_vld_q || pop) begin
      if (skid_vld_q) begin
        out_q <= skid_q;
      end else if (push_i) begin
        out_q <= push_data_i;
      end
    end else if (push_i) begin
      skid_q <= push_data_i;
    end
  end

  a_skid_implies_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid holds a word while output is empty");

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> !push_i)
    else $error("word pushed into full buffer");

  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_vld_q && out_rdy_i) |=> (!skid_vld_q && out_vld_q))
    else $error("skid word not moved to output");

endmodule

// ===== hdl/uart_frame_deframer_crc16.sv =====
// ----------------------------------------------------------------------------
// uart_frame_deframer_crc16: framed byte-stream parser with CRC-16 check
// Top level: frame state machine followed by an output buffer.
// ----------------------------------------------------------------------------
// Usage:
//   Slave side takes one received byte per word (s_axis_tdata_i[7:0]).
//   Frames are E6 E6, seq (2, big-endian), command, length (2), payload,
//   CRC-16 (2, big-endian), 6E 6E. Each payload byte comes out on the
//   master side with tuser = 0; one report word with tuser = 1 closes the
//   frame, or follows the length bytes at once when the length is above
//   max_payload (capped at 256).
//   Throughput: one byte per cycle while s_axis_tready_o is high; the CRC byte update and the state
//   machine step both fit in the cycle that accepts the byte.
//   Output: a result word is registered in the output register, or in the
//   skid stage while the output register still waits on the receiver.
//   Stall: the output register plus a skid stage hold up to two words;
//   s_axis_tready_o drops only while the skid stage is occupied.
//   Reset: hunting for the first header byte, max_payload = 256, output
//   empty. Write max_payload through cfg_we_i / cfg_wdata_i while idle.
// ----------------------------------------------------------------------------
module uart_frame_deframer_crc16 (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [8:0]  cfg_wdata_i,     // max_payload
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,  // [7:0] rx_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [7:0] data_byte, [9:8] status, [25:10] seq_num, [33:26] command,
  // [49:34] payload_len, [55:50] zero
  output logic [55:0] m_axis_tdata_o,
  output logic        m_axis_tuser_o   // [0] kind
);

  logic             in_acc;
  logic             res_vld;
  udf_pkg::result_t res;
  udf_pkg::result_t out_word;

  assign in_acc = s_axis_tvalid_i & s_axis_tready_o;

  udf_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .byte_vld_i  (in_acc),
    .byte_i      (s_axis_tdata_i),
    .res_vld_o   (res_vld),
    .res_o       (res)
  );

  udf_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_acc & res_vld),
    .push_data_i (res),
    .ready_o     (s_axis_tready_o),
    .out_vld_o   (m_axis_tvalid_o),
    .out_data_o  (out_word),
    .out_rdy_i   (m_axis_tready_i)
  );

  assign m_axis_tuser_o = out_word.kind;
  assign m_axis_tdata_o = {6'd0, out_word.payload_len, out_word.command,
                           out_word.seq_num, out_word.status, out_word.data_byte};

endmodule

// ===== verif/tb_uart_frame_deframer_crc16.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_uart_frame_deframer_crc16: self-checking bench for the frame deframer
// Feeds received bytes on the slave stream: a short table of fixed cases,
// then random frames with random payloads and random damage (bad CRC, bad
// tail, cut frames, line noise) under several max_payload settings. A
// byte-level model of the deframer predicts every payload and report word
// but the two that the fixed table gives; the master stream is checked
// word by word in order. Both sides stall at random except in one stretch.
// ----------------------------------------------------------------------------
module tb_uart_frame_deframer_crc16;

  localparam int CLK_HALF   = 5;
  localparam int ITEM_GOAL  = 1750;
  localparam int N_SETTINGS = 9;
  localparam int CYCLE_CAP  = 400000;
  localparam int DIR_ROWS   = 20;
  localparam int IDLE_PCT   = 18;

  localparam udf_pkg::result_t NO_WORD       = '0;
  localparam udf_pkg::result_t LEN_ERR_WORD  = '{udf_pkg::KIND_REPORT, 8'h00,
                                                 udf_pkg::ST_LEN_ERR,
                                                 16'hFFFF, 8'hFF, 16'hFFFF};
  localparam udf_pkg::result_t TAIL_ERR_WORD = '{udf_pkg::KIND_REPORT, 8'h00,
                                                 udf_pkg::ST_TAIL_ERR,
                                                 16'h0000, 8'h00, 16'h0000};

  typedef struct {
    logic [7:0]       rx;
    bit               typed;
    udf_pkg::result_t word;
  } dir_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we;
  logic [8:0]  cfg_wdata;
  logic        s_valid;
  logic        s_ready;
  logic [7:0]  s_data;
  logic        m_valid;
  logic        m_ready;
  logic [55:0] m_data;
  logic        m_user;

  // Deframer model state
  udf_pkg::phase_e fr_phase;
  logic [15:0]     fr_seq;
  logic [7:0]      fr_cmd;
  logic [15:0]     fr_len;
  logic [15:0]     fr_left;
  logic [15:0]     fr_crc;
  logic [15:0]     fr_rx_chk;
  logic            fr_tail_bad;
  logic [8:0]      fr_max;

  udf_pkg::result_t awaited_words[$];
  int               mismatch_cnt;
  int               cycle_cnt;
  bit               src_gaps;
  bit               sink_gaps;
  dir_row_t         dir_tbl [DIR_ROWS];

  uart_frame_deframer_crc16 dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user)
  );

  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_CAP) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    m_ready <= !sink_gaps || ($urandom_range(99) >= IDLE_PCT);
  end

  function automatic logic [15:0] crc_add(logic [15:0] acc, logic [7:0] b);
    logic [15:0] r;
    r = acc ^ {8'h00, b};
    repeat (8) r = {1'b0, r[15:1]} ^ (r[0] ? udf_pkg::CRC_POLY : 16'h0000);
    return r;
  endfunction

  task automatic model_reset();
    fr_phase    = udf_pkg::PH_HUNT1;
    fr_seq      = '0;
    fr_cmd      = '0;
    fr_len      = '0;
    fr_left     = '0;
    fr_crc      = udf_pkg::CRC_INIT;
    fr_rx_chk   = '0;
    fr_tail_bad = 1'b0;
    fr_max      = udf_pkg::MAX_PAYLOAD_RST;
  endtask

  // Advance the deframer model by one received byte.
  task automatic deframe_byte(input logic [7:0] b, output bit has_w,
                              output udf_pkg::result_t w);
    logic [8:0]       lim;
    udf_pkg::status_e st;
    has_w = 1'b0;
    w     = NO_WORD;
    case (fr_phase)
      udf_pkg::PH_HUNT1: begin
        if (b == udf_pkg::HDR_BYTE) fr_phase = udf_pkg::PH_HUNT2;
      end
      udf_pkg::PH_HUNT2: begin
        fr_phase    = (b == udf_pkg::HDR_BYTE) ? udf_pkg::PH_SEQ_HI : udf_pkg::PH_HUNT1;
        fr_crc      = udf_pkg::CRC_INIT;
        fr_tail_bad = 1'b0;
      end
      udf_pkg::PH_SEQ_HI: begin
        fr_crc   = crc_add(fr_crc, b);
        fr_seq   = {b, 8'h00};
        fr_phase = udf_pkg::PH_SEQ_LO;
      end
      udf_pkg::PH_SEQ_LO: begin
        fr_crc      = crc_add(fr_crc, b);
        fr_seq[7:0] = b;
        fr_phase    = udf_pkg::PH_CMD;
      end
      udf_pkg::PH_CMD: begin
        fr_crc   = crc_add(fr_crc, b);
        fr_cmd   = b;
        fr_phase = udf_pkg::PH_LEN_HI;
      end
      udf_pkg::PH_LEN_HI: begin
        fr_crc   = crc_add(fr_crc, b);
        fr_len   = {b, 8'h00};
        fr_phase = udf_pkg::PH_LEN_LO;
      end
      udf_pkg::PH_LEN_LO: begin
        fr_crc      = crc_add(fr_crc, b);
        fr_len[7:0] = b;
        lim = (fr_max > udf_pkg::PAYLOAD_LIMIT) ? udf_pkg::PAYLOAD_LIMIT : fr_max;
        if (fr_len > {7'd0, lim}) begin
          fr_phase = udf_pkg::PH_HUNT1;
          has_w    = 1'b1;
          w        = '{udf_pkg::KIND_REPORT, 8'h00, udf_pkg::ST_LEN_ERR,
                       fr_seq, fr_cmd, fr_len};
        end else begin
          fr_left  = fr_len;
          fr_phase = (fr_len == 16'd0) ? udf_pkg::PH_CHK_HI : udf_pkg::PH_DATA;
        end
      end
      udf_pkg::PH_DATA: begin
        fr_crc  = crc_add(fr_crc, b);
        fr_left = fr_left - 16'd1;
        if (fr_left == 16'd0) fr_phase = udf_pkg::PH_CHK_HI;
        has_w = 1'b1;
        w     = '{udf_pkg::KIND_PAYLOAD, b, udf_pkg::ST_VALID, fr_seq, fr_cmd, fr_len};
      end
      udf_pkg::PH_CHK_HI: begin
        fr_rx_chk = {b, 8'h00};
        fr_phase  = udf_pkg::PH_CHK_LO;
      end
      udf_pkg::PH_CHK_LO: begin
        fr_rx_chk[7:0] = b;
        fr_phase       = udf_pkg::PH_TAIL1;
      end
      udf_pkg::PH_TAIL1: begin
        fr_tail_bad = (b != udf_pkg::TAIL_BYTE);
        fr_phase    = udf_pkg::PH_TAIL2;
      end
      udf_pkg::PH_TAIL2: begin
        if (b != udf_pkg::TAIL_BYTE) fr_tail_bad = 1'b1;
        // tail error wins over a checksum error
        if (fr_tail_bad) st = udf_pkg::ST_TAIL_ERR;
        else if (~fr_crc != fr_rx_chk) st = udf_pkg::ST_CRC_ERR;
        else st = udf_pkg::ST_VALID;
        fr_phase = udf_pkg::PH_HUNT1;
        has_w    = 1'b1;
        w        = '{udf_pkg::KIND_REPORT, 8'h00, st, fr_seq, fr_cmd, fr_len};
      end
      default: fr_phase = udf_pkg::PH_HUNT1;
    endcase
  endtask

  // Offer one byte on the slave side and hold it until accepted.
  task automatic push_byte(input logic [7:0] b, input bit typed,
                           input udf_pkg::result_t typed_w);
    bit               has_w;
    udf_pkg::result_t w;
    @(negedge clk_i);
    while (src_gaps && $urandom_range(99) < IDLE_PCT) begin
      s_valid <= 1'b0;
      @(negedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= b;
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
    deframe_byte(b, has_w, w);
    if (typed) awaited_words.push_back(typed_w);
    else if (has_w) awaited_words.push_back(w);
  endtask

  task automatic drain_words();
    while (awaited_words.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_max_payload(input logic [8:0] v);
    @(negedge clk_i);
    s_valid <= 1'b0;
    drain_words();
    // a byte without a result may still be in flight
    repeat (4) @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    fr_max = v;
  endtask

  // Build one frame with random content and damage, then send it.
  task automatic send_frame(inout int sent);
    logic [7:0]  fb[$];
    logic [15:0] seq;
    logic [15:0] len;
    logic [15:0] crc;
    logic [15:0] chk;
    logic [7:0]  cmd;
    logic [7:0]  pb;
    logic [8:0]  lim;
    int          r;
    int          n;
    lim = (fr_max > udf_pkg::PAYLOAD_LIMIT) ? udf_pkg::PAYLOAD_LIMIT : fr_max;
    seq = 16'($urandom_range(0, 65535));
    cmd = 8'($urandom_range(0, 255));
    r   = $urandom_range(99);
    if (r < 60) len = 16'($urandom_range(0, 6));
    else if (r < 82) begin
      if (lim <= 9'd16) len = 16'(int'(lim) + $urandom_range(0, 2) - 1);
      else len = 16'($urandom_range(7, 20));
    end else if (r < 97) len = 16'($urandom_range(0, 65535));
    else len = {7'd0, lim};

    // line noise, sometimes with header bytes in it
    if ($urandom_range(99) < 10) begin
      n = $urandom_range(1, 4);
      repeat (n) begin
        pb = ($urandom_range(2) == 0) ? udf_pkg::HDR_BYTE : 8'($urandom_range(0, 255));
        push_byte(pb, 1'b0, NO_WORD);
      end
    end

    fb = {udf_pkg::HDR_BYTE, udf_pkg::HDR_BYTE, seq[15:8], seq[7:0], cmd,
          len[15:8], len[7:0]};
    crc = udf_pkg::CRC_INIT;
    for (int i = 2; i < 7; i++) crc = crc_add(crc, fb[i]);
    if (len <= {7'd0, lim}) begin
      for (int i = 0; i < int'(len); i++) begin
        r = $urandom_range(7);
        if (r == 0) pb = udf_pkg::HDR_BYTE;
        else if (r == 1) pb = udf_pkg::TAIL_BYTE;
        else pb = 8'($urandom_range(0, 255));
        crc = crc_add(crc, pb);
        fb.push_back(pb);
      end
      chk = ~crc;
      if ($urandom_range(99) < 15) chk = chk ^ 16'($urandom_range(1, 65535));
      fb.push_back(chk[15:8]);
      fb.push_back(chk[7:0]);
      fb.push_back(($urandom_range(99) < 8) ? 8'($urandom_range(0, 255))
                                             : udf_pkg::TAIL_BYTE);
      fb.push_back(($urandom_range(99) < 8) ? 8'($urandom_range(0, 255))
                                             : udf_pkg::TAIL_BYTE);
    end

    // cut the frame short now and then
    n = fb.size();
    if ($urandom_range(99) < 5) n = $urandom_range(1, fb.size() - 1);
    for (int i = 0; i < n; i++) push_byte(fb[i], 1'b0, NO_WORD);
    sent += n;
  endtask

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatch_cnt++;
    end
  endfunction

  always @(posedge clk_i) begin : out_check
    udf_pkg::result_t w;
    if (rst_ni && m_valid && m_ready) begin
      if (awaited_words.size() == 0) begin
        $error("word with no expectation: tuser 0x%0h tdata 0x%0h", m_user, m_data);
        mismatch_cnt++;
      end else begin
        w = awaited_words.pop_front();
        check_field("kind", 16'(w.kind), 16'(m_user));
        check_field("data_byte", 16'(w.data_byte), 16'(m_data[7:0]));
        check_field("status", 16'(w.status), 16'(m_data[9:8]));
        check_field("seq_num", w.seq_num, m_data[25:10]);
        check_field("command", 16'(w.command), 16'(m_data[33:26]));
        check_field("payload_len", w.payload_len, m_data[49:34]);
      end
    end
  end

  initial begin : stim
    logic [8:0] settings [N_SETTINGS];
    int         sent;
    int         goal;
    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    s_valid      = 1'b0;
    s_data       = '0;
    m_ready      = 1'b0;
    mismatch_cnt = 0;
    cycle_cnt    = 0;
    src_gaps     = 1'b1;
    sink_gaps    = 1'b1;
    model_reset();

    // broken header, oversized length at the field extremes, then an empty
    // frame whose tail and checksum are both wrong
    dir_tbl = '{
      '{8'hE6, 1'b0, NO_WORD}, '{8'h55, 1'b0, NO_WORD},
      '{8'hE6, 1'b0, NO_WORD}, '{8'hE6, 1'b0, NO_WORD},
      '{8'hFF, 1'b0, NO_WORD}, '{8'hFF, 1'b0, NO_WORD},
      '{8'hFF, 1'b0, NO_WORD}, '{8'hFF, 1'b0, NO_WORD},
      '{8'hFF, 1'b1, LEN_ERR_WORD},
      '{8'hE6, 1'b0, NO_WORD}, '{8'hE6, 1'b0, NO_WORD},
      '{8'h00, 1'b0, NO_WORD}, '{8'h00, 1'b0, NO_WORD},
      '{8'h00, 1'b0, NO_WORD}, '{8'h00, 1'b0, NO_WORD},
      '{8'h00, 1'b0, NO_WORD}, '{8'h12, 1'b0, NO_WORD},
      '{8'h34, 1'b0, NO_WORD}, '{8'h6E, 1'b0, NO_WORD},
      '{8'h00, 1'b1, TAIL_ERR_WORD}
    };
    settings = '{9'd0, 9'd1, 9'd5, 9'd256, 9'd12, 9'd511, 9'd300, 9'd3, 9'd256};
    settings[N_SETTINGS-1] = 9'($urandom_range(0, 511));

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_tbl[i]) push_byte(dir_tbl[i].rx, dir_tbl[i].typed, dir_tbl[i].word);

    sent = 0;
    for (int p = 0; p < N_SETTINGS; p++) begin
      write_max_payload(settings[p]);
      // one stretch without stalls on either side
      src_gaps  = (p != 3);
      sink_gaps = (p != 3);
      goal = (ITEM_GOAL * (p + 1)) / N_SETTINGS;
      while (sent < goal) send_frame(sent);
    end
    src_gaps  = 1'b1;
    sink_gaps = 1'b1;

    @(negedge clk_i);
    s_valid <= 1'b0;
    drain_words();
    repeat (8) @(negedge clk_i);
    if (mismatch_cnt == 0 && awaited_words.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
